### rtl/energy_spectrum_histogrammer_unit_macros.svh
`ifndef ENERGY_SPECTRUM_HISTOGRAMMER_UNIT_MACROS_SVH
`define ENERGY_SPECTRUM_HISTOGRAMMER_UNIT_MACROS_SVH

// Concurrent check on the rising clock edge, held off while reset is low
`define ESH_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check with the block's own clock and reset names
`define ESH_ASSERT_CR(lbl, prop, msg) \
  `ESH_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

### rtl/esh_pkg.sv
package esh_pkg;

  // Spectrum geometry
  localparam int NUM_BINS    = 1024;
  localparam int NUM_ORIGINS = 3;
  localparam int OUT_CATS    = 3;
  localparam int BIN_W       = $clog2(NUM_BINS);
  localparam int COLS        = NUM_ORIGINS + 1;

  // Field widths
  localparam int CNT_W   = 32;
  localparam int EN_W    = 24;
  localparam int WIDTH_W = 16;
  localparam int CAT_W   = 3;
  localparam int IDX_W   = 10;
  localparam int CMD_W   = 2;
  localparam int ROW_W   = COLS * CNT_W;

  // Bin divider: quotient bits resolved per cycle
  localparam int DIV_STEPS  = 4;
  localparam int DIV_CYCLES = EN_W / DIV_STEPS;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef logic [CNT_W-1:0]     count_t;
  typedef logic [BIN_W-1:0]     bin_t;
  typedef logic [WIDTH_W-1:0]   width_t;
  typedef logic [CAT_W-1:0]     cat_t;
  typedef logic [DIV_CNT_W-1:0] div_cnt_t;
  typedef logic [QPTR_W-1:0]    qptr_t;
  typedef logic [QPTR_W:0]      qcnt_t;

  localparam width_t BIN_WIDTH_RESET = 16'd1000;
  localparam count_t SAT_MAX         = '1;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_RECORD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

  // Classified operation handed from front to back
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             hit;
    logic             bin_ok;
    cat_t             cat;
    bin_t             addr;
  } op_t;

  function automatic count_t sat_inc(count_t c);
    return (c == SAT_MAX) ? c : c + count_t'(1);
  endfunction

endpackage

### rtl/esh_if.sv
interface esh_in_if;
  logic                       valid;
  logic                       ready;
  logic [esh_pkg::CMD_W-1:0]  command;
  logic [esh_pkg::EN_W-1:0]   energy_ev;
  logic [esh_pkg::CAT_W-1:0]  origin_category;
  logic [esh_pkg::IDX_W-1:0]  read_index;

  modport source (output valid, command, energy_ev, origin_category, read_index,
                  input ready);
  modport sink   (input valid, command, energy_ev, origin_category, read_index,
                  output ready);
endinterface

interface esh_out_if;
  logic                  valid;
  logic                  ready;
  esh_pkg::count_t       event_total;
  esh_pkg::count_t       hit_total;
  esh_pkg::count_t       hits_direct;
  esh_pkg::count_t       hits_scattered;
  esh_pkg::count_t       hits_born;
  esh_pkg::count_t       bin_count;
  esh_pkg::count_t       bin_direct;
  esh_pkg::count_t       bin_scattered;
  esh_pkg::count_t       bin_born;
  logic                  binned;

  modport source (output valid, event_total, hit_total, hits_direct, hits_scattered,
                  hits_born, bin_count, bin_direct, bin_scattered, bin_born, binned,
                  input ready);
  modport sink   (input valid, event_total, hit_total, hits_direct, hits_scattered,
                  hits_born, bin_count, bin_direct, bin_scattered, bin_born, binned,
                  output ready);
endinterface

### rtl/esh_front.sv
module esh_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  esh_pkg::width_t bin_width_i,
  esh_in_if.sink          req_i,
  output esh_pkg::op_t    op_o,
  output logic            op_valid_o,
  input  logic            op_ready_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;

  logic [1:0]               state_q, state_d;
  esh_pkg::div_cnt_t        cnt_q, cnt_d;
  logic [esh_pkg::EN_W-1:0] quo_q, quo_d, quo_v;
  esh_pkg::width_t          rem_q, rem_d, rem_v;
  esh_pkg::width_t          dsr_q, dsr_d;
  esh_pkg::op_t             op_q, op_d;

  // Restoring division, several quotient bits per cycle
  always_comb begin
    logic [esh_pkg::WIDTH_W:0] trial;
    rem_v = rem_q;
    quo_v = quo_q;
    for (int s = 0; s < esh_pkg::DIV_STEPS; s++) begin
      trial = {rem_v, quo_v[esh_pkg::EN_W-1]};
      quo_v = {quo_v[esh_pkg::EN_W-2:0], 1'b0};
      if (trial >= {1'b0, dsr_q}) begin
        trial    = trial - {1'b0, dsr_q};
        quo_v[0] = 1'b1;
      end
      rem_v = trial[esh_pkg::WIDTH_W-1:0];
    end
  end

  // Accept, classify and divide
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    dsr_d   = dsr_q;
    op_d    = op_q;
    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          op_d.cmd    = req_i.command;
          op_d.cat    = req_i.origin_category;
          op_d.hit    = (req_i.command == esh_pkg::CMD_RECORD) && (req_i.energy_ev != '0);
          op_d.bin_ok = (req_i.command == esh_pkg::CMD_READ) &&
                        (esh_pkg::count_t'(req_i.read_index) <
                         esh_pkg::count_t'(esh_pkg::NUM_BINS));
          op_d.addr   = (req_i.command == esh_pkg::CMD_READ) ?
                        esh_pkg::bin_t'(req_i.read_index) : '0;
          quo_d       = req_i.energy_ev;
          rem_d       = '0;
          dsr_d       = (bin_width_i == '0) ? esh_pkg::width_t'(1) : bin_width_i;
          cnt_d       = '0;
          state_d     = op_d.hit ? ST_DIV : ST_PUSH;
        end
      end
      ST_DIV: begin
        quo_d = quo_v;
        rem_d = rem_v;
        cnt_d = cnt_q + esh_pkg::div_cnt_t'(1);
        if (cnt_q == esh_pkg::div_cnt_t'(esh_pkg::DIV_CYCLES - 1)) begin
          op_d.bin_ok = esh_pkg::count_t'(quo_v) < esh_pkg::count_t'(esh_pkg::NUM_BINS);
          op_d.addr   = esh_pkg::bin_t'(quo_v);
          state_d     = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (op_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    op_q  <= op_d;
  end

  assign req_i.ready = (state_q == ST_IDLE);
  assign op_valid_o  = (state_q == ST_PUSH);
  assign op_o        = op_q;

endmodule

### rtl/esh_queue.sv
module esh_queue (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  esh_pkg::op_t push_op_i,
  input  logic         push_valid_i,
  output logic         push_ready_o,
  output esh_pkg::op_t pop_op_o,
  output logic         pop_valid_o,
  input  logic         pop_ready_i
);

  esh_pkg::op_t   entry_q [esh_pkg::QUEUE_DEPTH];
  esh_pkg::qptr_t wr_ptr_q, rd_ptr_q;
  esh_pkg::qcnt_t count_q;
  logic           push, pop;

  assign push_ready_o = (count_q != esh_pkg::qcnt_t'(esh_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_op_o     = entry_q[rd_ptr_q];

  function automatic esh_pkg::qptr_t wrap_inc(esh_pkg::qptr_t p);
    return (p == esh_pkg::qptr_t'(esh_pkg::QUEUE_DEPTH - 1)) ? '0 : p + esh_pkg::qptr_t'(1);
  endfunction

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wrap_inc(wr_ptr_q);
      end
      if (pop) begin
        rd_ptr_q <= wrap_inc(rd_ptr_q);
      end
      if (push && !pop) begin
        count_q <= count_q + esh_pkg::qcnt_t'(1);
      end else if (pop && !push) begin
        count_q <= count_q - esh_pkg::qcnt_t'(1);
      end
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_op_i;
    end
  end

endmodule

### rtl/esh_back.sv
module esh_back (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  esh_pkg::op_t op_i,
  input  logic         op_valid_i,
  output logic         op_ready_o,
  esh_out_if.source    rsp_o
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_ACT   = 2'd2;

  logic [1:0]                 state_q, state_d;
  esh_pkg::bin_t              sweep_q, sweep_d;
  esh_pkg::op_t               cur_q;
  logic [esh_pkg::ROW_W-1:0]  mem_q [esh_pkg::NUM_BINS];
  logic [esh_pkg::ROW_W-1:0]  rd_row_q, row_v, mem_wdata;
  esh_pkg::bin_t              mem_addr;
  logic                       mem_we;
  esh_pkg::count_t            event_q, event_d, hit_q, hit_d;
  esh_pkg::count_t            orig_q [esh_pkg::NUM_ORIGINS];
  esh_pkg::count_t            orig_d [esh_pkg::NUM_ORIGINS];
  esh_pkg::count_t            orig_ext [esh_pkg::OUT_CATS];
  esh_pkg::count_t            bin_ext [esh_pkg::OUT_CATS + 1];
  logic                       binned_v;
  logic                       out_free, pop, fire;

  // Result register
  logic                       rsp_valid_q;
  esh_pkg::count_t            r_event_q, r_hit_q, r_direct_q, r_scat_q, r_born_q;
  esh_pkg::count_t            r_bin_q, r_bdirect_q, r_bscat_q, r_bborn_q;
  logic                       r_binned_q;

  assign out_free   = !rsp_valid_q || rsp_o.ready;
  assign op_ready_o = (state_q == ST_IDLE);
  assign pop        = (state_q == ST_IDLE) && op_valid_i;
  assign fire       = (state_q == ST_ACT) && out_free;

  // Sweep, read-modify-write and counter update
  always_comb begin
    state_d   = state_q;
    sweep_d   = sweep_q;
    event_d   = event_q;
    hit_d     = hit_q;
    orig_d    = orig_q;
    row_v     = rd_row_q;
    binned_v  = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = sweep_q;
    mem_wdata = '0;
    for (int c = 0; c <= esh_pkg::OUT_CATS; c++) begin
      bin_ext[c] = '0;
    end
    case (state_q)
      ST_CLEAR: begin
        mem_we  = 1'b1;
        sweep_d = sweep_q + esh_pkg::bin_t'(1);
        if (sweep_q == esh_pkg::bin_t'(esh_pkg::NUM_BINS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (op_valid_i) begin
          state_d = ST_ACT;
        end
      end
      ST_ACT: begin
        if (out_free) begin
          state_d = ST_IDLE;
          case (cur_q.cmd)
            esh_pkg::CMD_RECORD: begin
              event_d = esh_pkg::sat_inc(event_q);
              if (cur_q.hit) begin
                hit_d = esh_pkg::sat_inc(hit_q);
              end
              if (cur_q.bin_ok) begin
                binned_v = 1'b1;
                row_v[esh_pkg::CNT_W-1:0] = esh_pkg::sat_inc(rd_row_q[esh_pkg::CNT_W-1:0]);
                for (int c = 0; c < esh_pkg::NUM_ORIGINS; c++) begin
                  if (cur_q.cat == esh_pkg::cat_t'(c)) begin
                    row_v[(c+1)*esh_pkg::CNT_W +: esh_pkg::CNT_W] =
                      esh_pkg::sat_inc(rd_row_q[(c+1)*esh_pkg::CNT_W +: esh_pkg::CNT_W]);
                    orig_d[c] = esh_pkg::sat_inc(orig_q[c]);
                  end
                end
                mem_we    = 1'b1;
                mem_addr  = cur_q.addr;
                mem_wdata = row_v;
              end
            end
            esh_pkg::CMD_READ: begin
              if (cur_q.bin_ok) begin
                bin_ext[0] = rd_row_q[esh_pkg::CNT_W-1:0];
                for (int c = 0; c < esh_pkg::NUM_ORIGINS; c++) begin
                  bin_ext[c+1] = rd_row_q[(c+1)*esh_pkg::CNT_W +: esh_pkg::CNT_W];
                end
              end
            end
            esh_pkg::CMD_CLEAR: begin
              event_d = '0;
              hit_d   = '0;
              for (int c = 0; c < esh_pkg::NUM_ORIGINS; c++) begin
                orig_d[c] = '0;
              end
              sweep_d = '0;
              state_d = ST_CLEAR;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Pad category counters to the output set
  always_comb begin
    for (int c = 0; c < esh_pkg::OUT_CATS; c++) begin
      orig_ext[c] = '0;
    end
    for (int c = 0; c < esh_pkg::NUM_ORIGINS; c++) begin
      orig_ext[c] = orig_d[c];
    end
  end

  // Control state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      sweep_q     <= '0;
      event_q     <= '0;
      hit_q       <= '0;
      rsp_valid_q <= 1'b0;
      for (int c = 0; c < esh_pkg::NUM_ORIGINS; c++) begin
        orig_q[c] <= '0;
      end
    end else begin
      state_q <= state_d;
      sweep_q <= sweep_d;
      event_q <= event_d;
      hit_q   <= hit_d;
      orig_q  <= orig_d;
      if (fire) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Spectrum memory: one row per bin, total then one column per category
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end
    if (pop) begin
      rd_row_q <= mem_q[op_i.addr];
      cur_q    <= op_i;
    end
  end

  // Load the result
  always_ff @(posedge clk_i) begin
    if (fire) begin
      r_event_q   <= event_d;
      r_hit_q     <= hit_d;
      r_direct_q  <= orig_ext[0];
      r_scat_q    <= orig_ext[1];
      r_born_q    <= orig_ext[2];
      r_bin_q     <= bin_ext[0];
      r_bdirect_q <= bin_ext[1];
      r_bscat_q   <= bin_ext[2];
      r_bborn_q   <= bin_ext[3];
      r_binned_q  <= binned_v;
    end
  end

  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.event_total    = r_event_q;
  assign rsp_o.hit_total      = r_hit_q;
  assign rsp_o.hits_direct    = r_direct_q;
  assign rsp_o.hits_scattered = r_scat_q;
  assign rsp_o.hits_born      = r_born_q;
  assign rsp_o.bin_count      = r_bin_q;
  assign rsp_o.bin_direct     = r_bdirect_q;
  assign rsp_o.bin_scattered  = r_bscat_q;
  assign rsp_o.bin_born       = r_bborn_q;
  assign rsp_o.binned         = r_binned_q;

endmodule

### rtl/energy_spectrum_histogrammer_unit.sv
// Channel   Direction  Transaction   Payload
// req_i     in         valid/ready   command, energy_ev, origin_category, read_index
// rsp_o     out        valid/ready   counters, four bin counts, binned
// cfg       in         cfg_we_i      cfg_wdata_i = bin width in eV
//
// A record with energy passes the front as accept, division of the energy by
// the bin width and hand-off; other commands skip the division. The back reads
// the bin row, then finishes once the output register is free; a record writes
// the row back. Reset and every clear start a sweep that zeroes every bin row,
// one row a cycle; meanwhile the back takes none and the front and queue fill.
// A stalled result holds in the output register while four more transactions
// are accepted: one waits in the back, two in the queue and one in the front.
module energy_spectrum_histogrammer_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  esh_pkg::width_t cfg_wdata_i,
  esh_in_if.sink          req_i,
  esh_out_if.source       rsp_o
);

  esh_pkg::width_t bin_width_q;
  esh_pkg::op_t    f_op, b_op;
  logic            f_valid, f_ready, b_valid, b_ready;

  // Bin width register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_width_q <= esh_pkg::BIN_WIDTH_RESET;
    end else if (cfg_we_i) begin
      bin_width_q <= cfg_wdata_i;
    end
  end

  esh_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .bin_width_i (bin_width_q),
    .req_i       (req_i),
    .op_o        (f_op),
    .op_valid_o  (f_valid),
    .op_ready_i  (f_ready)
  );

  esh_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_op_i    (f_op),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .pop_op_o     (b_op),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready)
  );

  esh_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (b_op),
    .op_valid_i (b_valid),
    .op_ready_o (b_ready),
    .rsp_o      (rsp_o)
  );

endmodule

### rtl/esh_checker.sv
`include "energy_spectrum_histogrammer_unit_macros.svh"

module esh_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            req_valid_i,
  input logic            req_ready_i,
  input logic            rsp_valid_i,
  input logic            rsp_ready_i,
  input logic            rsp_binned_i,
  input esh_pkg::count_t rsp_bin_count_i,
  input esh_pkg::count_t rsp_bin_direct_i,
  input esh_pkg::count_t rsp_bin_scattered_i,
  input esh_pkg::count_t rsp_bin_born_i
);

  logic [3:0] pending_q;

  // Track transactions accepted but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + 4'(req_valid_i && req_ready_i)
                             - 4'(rsp_valid_i && rsp_ready_i);
    end
  end

  `ESH_ASSERT_CR(a_rsp_hold, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i, "result dropped")

  `ESH_ASSERT_CR(a_no_extra, rsp_valid_i |-> pending_q != 4'd0, "result without request")

  `ESH_ASSERT_CR(a_binned_no_bins, rsp_valid_i && rsp_binned_i |-> (rsp_bin_count_i == '0) && (rsp_bin_direct_i == '0) && (rsp_bin_scattered_i == '0) && (rsp_bin_born_i == '0), "bin fields on record")

  `ESH_ASSERT_CR(a_total_covers, rsp_valid_i |-> (rsp_bin_count_i >= rsp_bin_direct_i) && (rsp_bin_count_i >= rsp_bin_scattered_i) && (rsp_bin_count_i >= rsp_bin_born_i), "category bin above total")

endmodule

bind energy_spectrum_histogrammer_unit esh_checker u_esh_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .req_valid_i         (req_i.valid),
  .req_ready_i         (req_i.ready),
  .rsp_valid_i         (rsp_o.valid),
  .rsp_ready_i         (rsp_o.ready),
  .rsp_binned_i        (rsp_o.binned),
  .rsp_bin_count_i     (rsp_o.bin_count),
  .rsp_bin_direct_i    (rsp_o.bin_direct),
  .rsp_bin_scattered_i (rsp_o.bin_scattered),
  .rsp_bin_born_i      (rsp_o.bin_born)
);

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import esh_pkg::*;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [EN_W-1:0]  energy_ev;
    cat_t             origin_category;
    logic [IDX_W-1:0] read_index;
  } spectrum_cmd_t;

  typedef struct packed {
    count_t event_total;
    count_t hit_total;
    count_t hits_direct;
    count_t hits_scattered;
    count_t hits_born;
    count_t bin_count;
    count_t bin_direct;
    count_t bin_scattered;
    count_t bin_born;
    logic   binned;
  } spectrum_readout_t;

  localparam int          HOLD_CYCLES  = 300;
  localparam int          DRAIN_CYCLES = 40;
  localparam int          PHASE_ITEMS  = 70;
  localparam int          NUM_PHASES   = 7;
  localparam int unsigned ENERGY_MAX   = (1 << EN_W) - 1;

  logic   clk_i;
  logic   rst_ni;
  logic   cfg_we_i;
  width_t cfg_wdata_i;
  logic   hold_pulse;

  esh_in_if  req_if();
  esh_out_if rsp_if();

  energy_spectrum_histogrammer_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  // Predicted copy of the histogram state and the bin width
  width_t cur_bin_width;
  count_t events_seen;
  count_t hits_seen;
  count_t origin_hits [NUM_ORIGINS];
  count_t total_spec [NUM_BINS];
  count_t origin_spec [NUM_ORIGINS][NUM_BINS];

  spectrum_cmd_t     pending_cmds[$];
  spectrum_readout_t expected_readouts[$];
  spectrum_cmd_t     cmd_on_bus;
  int unsigned       hot_bins [8];

  int error_count;
  int n_checked;
  int n_records;
  int n_hits;
  int n_binned;
  int n_reads;
  int n_clears;
  int n_unused;
  int n_width_writes;

  function automatic count_t saturating_inc(count_t c);
    return (c == '1) ? c : c + count_t'(1);
  endfunction

  function automatic void clear_spectra();
    events_seen = '0;
    hits_seen   = '0;
    for (int k = 0; k < NUM_ORIGINS; k++) begin
      origin_hits[k] = '0;
      for (int b = 0; b < NUM_BINS; b++) origin_spec[k][b] = '0;
    end
    for (int b = 0; b < NUM_BINS; b++) total_spec[b] = '0;
  endfunction

  function automatic count_t origin_hit_count(int k);
    return (k < NUM_ORIGINS) ? origin_hits[k] : '0;
  endfunction

  function automatic count_t origin_bin_count(int k, int unsigned b);
    return (k < NUM_ORIGINS && b < NUM_BINS) ? origin_spec[k][b] : '0;
  endfunction

  // Apply one command to the predicted spectra and return the readout it yields
  function automatic spectrum_readout_t update_spectra(spectrum_cmd_t c);
    spectrum_readout_t r;
    int unsigned       w;
    int unsigned       bin_no;
    int unsigned       cat;
    r   = '0;
    w   = (cur_bin_width == '0) ? 1 : int'(cur_bin_width);
    cat = c.origin_category;
    case (c.command)
      CMD_RECORD: begin
        n_records++;
        events_seen = saturating_inc(events_seen);
        if (c.energy_ev != '0) begin
          n_hits++;
          bin_no    = int'(c.energy_ev) / w;
          hits_seen = saturating_inc(hits_seen);
          if (bin_no < NUM_BINS) begin
            n_binned++;
            r.binned           = 1'b1;
            total_spec[bin_no] = saturating_inc(total_spec[bin_no]);
            if (cat < NUM_ORIGINS) begin
              origin_spec[cat][bin_no] = saturating_inc(origin_spec[cat][bin_no]);
              origin_hits[cat]         = saturating_inc(origin_hits[cat]);
            end
          end
        end
      end
      CMD_READ: begin
        n_reads++;
        if (c.read_index < NUM_BINS) begin
          r.bin_count     = total_spec[c.read_index];
          r.bin_direct    = origin_bin_count(0, c.read_index);
          r.bin_scattered = origin_bin_count(1, c.read_index);
          r.bin_born      = origin_bin_count(2, c.read_index);
        end
      end
      CMD_CLEAR: begin
        n_clears++;
        clear_spectra();
      end
      default: n_unused++;
    endcase
    r.event_total    = events_seen;
    r.hit_total      = hits_seen;
    r.hits_direct    = origin_hit_count(0);
    r.hits_scattered = origin_hit_count(1);
    r.hits_born      = origin_hit_count(2);
    return r;
  endfunction

  function automatic void check_field(string name, count_t want, count_t got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      error_count++;
    end
  endfunction

  // Compare a received readout against the oldest expectation
  function automatic void check_readout(spectrum_readout_t got);
    spectrum_readout_t want;
    if (expected_readouts.size() == 0) begin
      $display("%0t: readout received with none expected (event_total %0d)",
               $time, got.event_total);
      error_count++;
      return;
    end
    want = expected_readouts.pop_front();
    n_checked++;
    check_field("event_total", want.event_total, got.event_total);
    check_field("hit_total", want.hit_total, got.hit_total);
    check_field("hits_direct", want.hits_direct, got.hits_direct);
    check_field("hits_scattered", want.hits_scattered, got.hits_scattered);
    check_field("hits_born", want.hits_born, got.hits_born);
    check_field("bin_count", want.bin_count, got.bin_count);
    check_field("bin_direct", want.bin_direct, got.bin_direct);
    check_field("bin_scattered", want.bin_scattered, got.bin_scattered);
    check_field("bin_born", want.bin_born, got.bin_born);
    check_field("binned", count_t'(want.binned), count_t'(got.binned));
  endfunction

  function automatic void push_cmd(logic [CMD_W-1:0] cmd, int unsigned energy,
                                   int unsigned cat, int unsigned idx);
    spectrum_cmd_t c;
    c.command         = cmd;
    c.energy_ev       = EN_W'(energy);
    c.origin_category = CAT_W'(cat);
    c.read_index      = IDX_W'(idx);
    pending_cmds.push_back(c);
  endfunction

  function automatic int unsigned pick_bin_no();
    return ($urandom_range(0, 1) == 0) ? hot_bins[$urandom_range(0, 7)]
                                       : $urandom_range(0, NUM_BINS - 1);
  endfunction

  function automatic void refresh_hot_bins();
    hot_bins[0] = 0;
    hot_bins[1] = NUM_BINS - 1;
    for (int k = 2; k < 8; k++) hot_bins[k] = $urandom_range(0, NUM_BINS - 1);
  endfunction

  // Records either side of the spectrum top for this width, then a read of the top bin
  function automatic void queue_edge_records();
    longint unsigned w;
    longint unsigned top;
    w   = (cur_bin_width == '0) ? 1 : cur_bin_width;
    top = w * NUM_BINS;
    if (top - 1 <= ENERGY_MAX) push_cmd(CMD_RECORD, 32'(top - 1), $urandom_range(0, 7), 0);
    if (top <= ENERGY_MAX) push_cmd(CMD_RECORD, 32'(top), $urandom_range(0, 7), 0);
    push_cmd(CMD_READ, 0, 0, NUM_BINS - 1);
  endfunction

  // Mostly records aimed at a few busy bins, with reads of those bins, some noise
  function automatic void queue_random_cmds(int n);
    int unsigned     roll;
    longint unsigned w;
    longint unsigned e;
    w = (cur_bin_width == '0) ? 1 : cur_bin_width;
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        push_cmd(CMD_CLEAR, $urandom, $urandom, $urandom);
      end else if (roll < 6) begin
        push_cmd(CMD_NOP, $urandom, $urandom, $urandom);
      end else if (roll < 30) begin
        push_cmd(CMD_READ, $urandom, $urandom,
                 ($urandom_range(0, 3) == 0) ? $urandom : pick_bin_no());
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
          e = 0;
        end else if (roll < 25) begin
          e = $urandom & ENERGY_MAX;
        end else begin
          e = longint'(pick_bin_no()) * w + $urandom_range(0, 32'(w - 1));
          if (e > ENERGY_MAX) e = $urandom & ENERGY_MAX;
        end
        push_cmd(CMD_RECORD, 32'(e),
                 ($urandom_range(0, 9) < 7) ? $urandom_range(0, NUM_ORIGINS - 1)
                                            : $urandom_range(NUM_ORIGINS, 7),
                 $urandom);
      end
    end
  endfunction

  // Block until nothing is queued, offered or outstanding; sample on the falling edge
  task automatic wait_idle();
    @(negedge clk_i);
    while (pending_cmds.size() != 0 || req_if.valid || expected_readouts.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_bin_width(width_t w);
    @(posedge clk_i);
    cfg_we_i      <= 1'b1;
    cfg_wdata_i   <= w;
    cur_bin_width = w;
    n_width_writes++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Driver: offer queued commands in bursts separated by random gaps
  int burst_left;
  int gap_left;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      burst_left   = 0;
      gap_left     = 0;
    end else begin
      if (req_if.valid && req_if.ready) expected_readouts.push_back(update_spectra(cmd_on_bus));
      if (!req_if.valid || req_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          req_if.valid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          cmd_on_bus             = pending_cmds.pop_front();
          req_if.command         <= cmd_on_bus.command;
          req_if.energy_ev       <= cmd_on_bus.energy_ev;
          req_if.origin_category <= cmd_on_bus.origin_category;
          req_if.read_index      <= cmd_on_bus.read_index;
          req_if.valid           <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 30);
            gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 25)
                                                     : $urandom_range(1, 6);
          end
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each readout transaction, stall the response side on its own pattern
  int hold_left;
  int mode_left;
  int stall_mode;
  int cycle_no;

  always @(posedge clk_i) begin : monitor
    spectrum_readout_t got;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      hold_left    = 0;
      mode_left    = 0;
      stall_mode   = 0;
      cycle_no     = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        got.event_total    = rsp_if.event_total;
        got.hit_total      = rsp_if.hit_total;
        got.hits_direct    = rsp_if.hits_direct;
        got.hits_scattered = rsp_if.hits_scattered;
        got.hits_born      = rsp_if.hits_born;
        got.bin_count      = rsp_if.bin_count;
        got.bin_direct     = rsp_if.bin_direct;
        got.bin_scattered  = rsp_if.bin_scattered;
        got.bin_born       = rsp_if.bin_born;
        got.binned         = rsp_if.binned;
        check_readout(got);
      end
      cycle_no++;
      if (hold_pulse) hold_left = HOLD_CYCLES;
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 80);
      end else begin
        mode_left--;
      end
      // Hold off completely during a long stall, else follow the current pattern
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        case (stall_mode)
          0:       rsp_if.ready <= 1'b1;
          1:       rsp_if.ready <= $urandom_range(0, 1);
          2:       rsp_if.ready <= ($urandom_range(0, 4) != 0);
          default: rsp_if.ready <= (cycle_no % 8) < 4;
        endcase
      end
    end
  end

  // Stimulus and phase control
  initial begin
    width_t phase_widths [NUM_PHASES];
    rst_ni                 = 1'b0;
    cfg_we_i               = 1'b0;
    cfg_wdata_i            = '0;
    hold_pulse             = 1'b0;
    req_if.valid           = 1'b0;
    req_if.command         = CMD_RECORD;
    req_if.energy_ev       = '0;
    req_if.origin_category = '0;
    req_if.read_index      = '0;
    rsp_if.ready           = 1'b0;
    cur_bin_width          = BIN_WIDTH_RESET;
    clear_spectra();
    refresh_hot_bins();

    phase_widths[0] = '0;
    phase_widths[1] = width_t'(1);
    phase_widths[2] = '1;
    phase_widths[3] = width_t'(16384);
    phase_widths[4] = width_t'($urandom_range(2, 65534));
    phase_widths[5] = width_t'(17);
    phase_widths[6] = BIN_WIDTH_RESET;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset width, spectrum edges, every origin category, every command
    push_cmd(CMD_READ, 0, 0, 0);
    push_cmd(CMD_RECORD, 0, 0, 0);
    push_cmd(CMD_RECORD, 1, 0, 0);
    push_cmd(CMD_RECORD, 999, 1, 0);
    push_cmd(CMD_RECORD, 1000, 2, 0);
    push_cmd(CMD_RECORD, 1023999, 3, 0);
    push_cmd(CMD_RECORD, 1024000, 0, 0);
    push_cmd(CMD_RECORD, ENERGY_MAX, 7, 1023);
    push_cmd(CMD_READ, 0, 0, 0);
    push_cmd(CMD_READ, ENERGY_MAX, 7, 1);
    push_cmd(CMD_READ, 0, 0, NUM_BINS - 1);
    push_cmd(CMD_NOP, 1000, 1, 0);
    push_cmd(CMD_NOP, ENERGY_MAX, 7, 1023);
    push_cmd(CMD_CLEAR, 0, 0, 0);
    push_cmd(CMD_READ, 0, 0, 0);
    push_cmd(CMD_READ, 0, 0, 1);
    push_cmd(CMD_RECORD, 5000, 1, 0);
    push_cmd(CMD_READ, 0, 0, 5);

    // Random phases, one bin width each, written only with the block idle
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      write_bin_width(phase_widths[p]);
      refresh_hot_bins();
      queue_edge_records();
      queue_random_cmds(PHASE_ITEMS);
      if (p == 3) begin
        repeat (20) @(posedge clk_i);
        hold_pulse <= 1'b1;
        @(posedge clk_i);
        hold_pulse <= 1'b0;
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Checked %0d readouts: %0d records (%0d hits, %0d binned), %0d reads,",
             n_checked, n_records, n_hits, n_binned, n_reads);
    $display("%0d clears, %0d unused codes, over %0d bin width writes incl. 0, 1, 65535",
             n_clears, n_unused, n_width_writes);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("%0t: timeout with %0d commands queued and %0d readouts outstanding",
             $time, pending_cmds.size(), expected_readouts.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/esh_pkg.sv
rtl/esh_if.sv
rtl/esh_front.sv
rtl/esh_queue.sv
rtl/esh_back.sv
rtl/energy_spectrum_histogrammer_unit.sv
rtl/esh_checker.sv
dv/tb_top.sv
